/* src/sorted_table_binary_search_unit_assert.svh */
// Assertion macros shared by the sorted table binary search unit.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising edge while reset is released.
`define STBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds while reset is released.
`define STBS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define STBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define STBS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* src/stbs_pkg.sv */
// Types and constants of the sorted table binary search unit.
package stbs_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_FOUND = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PROBE = 1'b1
  } state_e;

  typedef struct packed {
    logic                         en;
    logic [ADDR_W-1:0]            addr;
    logic signed [DATA_WIDTH-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

/* src/stbs_table.sv */
// Entry store of the search unit: one write port, one registered read port.
module stbs_table (
  input  logic                                   clk_i,
  input  stbs_pkg::mem_wr_t                      wr_i,
  input  stbs_pkg::mem_rd_t                      rd_i,
  output logic signed [stbs_pkg::DATA_WIDTH-1:0] rd_data_o
);

  logic signed [stbs_pkg::DATA_WIDTH-1:0] mem_q [stbs_pkg::DEPTH];
  logic signed [stbs_pkg::DATA_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/sorted_table_binary_search_unit.sv */
// Sorted table with clear, append and binary search commands.
//
// Input channel (in_valid_i / in_ready_o) carries one request: a command and
// a signed value. Output channel (out_valid_o / out_ready_i) returns exactly
// one result per request: a status and a position.
// Clear and append finish in the cycle they are accepted; the result is
// visible on the next cycle. A search reads one table entry per cycle from
// the single read port of the entry store, with the compare and the next
// midpoint computed in the same cycle, so it takes one probe for each halving
// step: 1 to ceil(log2(count+1)) probes, at most 11 for 1024 entries. The
// block holds one request at a time; in_ready_o stays low while a search
// probes.
// The result sits in an output register. A new request is taken while that
// register is being drained in the same cycle; if the receiver stalls,
// in_ready_o stays low until the result is taken.
// Reset empties the table (the entry count goes to zero) and drops any
// pending result. Entry contents are not cleared; only written entries are
// ever read.
`include "sorted_table_binary_search_unit_assert.svh"

module sorted_table_binary_search_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [stbs_pkg::CMD_W-1:0]             command_i,
  input  logic signed [stbs_pkg::DATA_WIDTH-1:0] value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [stbs_pkg::STATUS_W-1:0]          status_o,
  output logic [stbs_pkg::POS_W-1:0]             position_o
);

  localparam int unsigned CW = stbs_pkg::CNT_W;
  localparam int unsigned AW = stbs_pkg::ADDR_W;

  stbs_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     hi_q, hi_d;     // exclusive upper bound
  logic [CW-1:0]     mid_q, mid_d;
  logic signed [stbs_pkg::DATA_WIDTH-1:0] key_q, key_d;
  logic              out_valid_q, out_valid_d;
  stbs_pkg::status_e status_q, status_d;
  logic [stbs_pkg::POS_W-1:0] pos_q, pos_d;

  logic [CW-1:0]     nlo, nhi;
  logic [CW:0]       msum;
  logic              accept;
  stbs_pkg::cmd_e    cmd;
  stbs_pkg::mem_wr_t mem_wr;
  stbs_pkg::mem_rd_t mem_rd;
  logic signed [stbs_pkg::DATA_WIDTH-1:0] rd_data;

  stbs_table u_table (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_data_o (rd_data)
  );

  assign in_ready_o = (state_q == stbs_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = stbs_pkg::cmd_e'(command_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    pos_d       = pos_q;
    mem_wr.en   = 1'b0;
    mem_wr.addr = count_q[AW-1:0];
    mem_wr.data = value_i;
    mem_rd.en   = 1'b0;
    mem_rd.addr = mid_q[AW-1:0];
    nlo         = lo_q;
    nhi         = hi_q;
    msum        = '0;

    case (state_q)
      stbs_pkg::S_IDLE: begin
        if (accept) begin
          status_d    = stbs_pkg::ST_DONE;
          pos_d       = '0;
          out_valid_d = 1'b1;
          case (cmd)
            stbs_pkg::CMD_CLEAR: begin
              count_d = '0;
            end
            stbs_pkg::CMD_APPEND: begin
              if (count_q == CW'(stbs_pkg::DEPTH)) begin
                status_d = stbs_pkg::ST_FULL;
              end else begin
                mem_wr.en = 1'b1;
                count_d   = count_q + CW'(1);
              end
            end
            stbs_pkg::CMD_SEARCH: begin
              if (count_q == '0) begin
                status_d = stbs_pkg::ST_MISS;
              end else begin
                out_valid_d = 1'b0;
                lo_d        = '0;
                hi_d        = count_q;
                mid_d       = (count_q - CW'(1)) >> 1;
                key_d       = value_i;
                mem_rd.en   = 1'b1;
                mem_rd.addr = mid_d[AW-1:0];
                state_d     = stbs_pkg::S_PROBE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      stbs_pkg::S_PROBE: begin
        if (rd_data == key_q) begin
          status_d    = stbs_pkg::ST_FOUND;
          pos_d       = stbs_pkg::POS_W'(mid_q);
          out_valid_d = 1'b1;
          state_d     = stbs_pkg::S_IDLE;
        end else begin
          if (key_q < rd_data) begin
            nhi = mid_q;
          end else begin
            nlo = mid_q + CW'(1);
          end
          lo_d = nlo;
          hi_d = nhi;
          if (nlo < nhi) begin
            // Both bounds are non-negative here, so the halved sum is the midpoint.
            msum        = {1'b0, nlo} + {1'b0, nhi} - (CW+1)'(1);
            mid_d       = msum[CW:1];
            mem_rd.en   = 1'b1;
            mem_rd.addr = mid_d[AW-1:0];
          end else begin
            status_d    = stbs_pkg::ST_MISS;
            pos_d       = '0;
            out_valid_d = 1'b1;
            state_d     = stbs_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = stbs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stbs_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    key_q    <= key_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;

  `STBS_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CW'(stbs_pkg::DEPTH), "entry count above table depth")
  `STBS_ASSERT(a_probe_no_result, clk_i, rst_ni, (state_q == stbs_pkg::S_PROBE) |-> !out_valid_q, "result pending while a search probes")
  `STBS_ASSERT(a_probe_bounds, clk_i, rst_ni, (state_q == stbs_pkg::S_PROBE) |-> (lo_q < hi_q && mid_q < hi_q), "search window empty while probing")
  `STBS_ASSERT(a_found_pos, clk_i, rst_ni, (out_valid_q && status_q == stbs_pkg::ST_FOUND) |-> (CW'(pos_q) < count_q), "found position beyond stored entries")

endmodule
